@@ design/running_box_blur_row_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the running box blur row core
// Short forms for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RUNNING_BOX_BLUR_ROW_CORE_ASSERT_SVH
`define RUNNING_BOX_BLUR_ROW_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RBB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RBB_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rbb_pkg.sv @@
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the running box blur row core.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int PIX_W          = 8;
  localparam int PIX_MAX        = (1 << PIX_W) - 1;
  localparam int RADIUS_CFG_W   = 4;
  localparam int DIM_CFG_W      = 13;
  localparam int ROW_W          = 12;
  localparam int ROWS_HIGH      = 4096;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam int RADIUS_MAX_DEF = 15;
  localparam int WIDTH_MAX_DEF  = 4096;

  localparam logic [RADIUS_CFG_W-1:0] RST_BOX_RADIUS = RADIUS_CFG_W'(1);
  localparam logic [DIM_CFG_W-1:0]    RST_ROW_WIDTH  = DIM_CFG_W'(640);
  localparam logic [DIM_CFG_W-1:0]    RST_ROW_COUNT  = DIM_CFG_W'(480);

  localparam int CMD_Q_DEPTH    = 2;
  localparam int OUT_Q_DEPTH    = 4;
  localparam int OUT_CNT_W      = $clog2(OUT_Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_RADIUS = 2'd0,
    CFG_ROW_WIDTH  = 2'd1,
    CFG_ROW_COUNT  = 2'd2
  } rbb_cfg_idx_t;

  // Classification of one accepted pixel, passed from front to back.
  typedef struct packed {
    logic first_col;  // column 0: seed the running sum
    logic remove;     // window full: drop the sample leaving on the left
    logic emit;       // a result is produced for this pixel
    logic row_end;    // last pixel of the row: flush the tail
    logic frame_end;  // row is the last of the frame
  } rbb_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_row;
    logic             last_frame;
  } rbb_result_t;

  typedef enum logic {
    BK_IDLE,
    BK_CALC
  } rbb_state_t;

endpackage

@@ design/rbb_ram.sv @@
// ----------------------------------------------------------------------------
// rbb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rbb_fifo.sv @@
// ----------------------------------------------------------------------------
// rbb_fifo
// Small synchronous FIFO with show-ahead read data and an occupancy count.
// ----------------------------------------------------------------------------
module rbb_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       pop,
  output logic [DATA_W-1:0]          rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign count   = count_r;
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ design/rbb_front.sv @@
// ----------------------------------------------------------------------------
// rbb_front
// Accepts pixels, tracks column and row, and classifies each pixel for the
// back end.
// ----------------------------------------------------------------------------
module rbb_front import rbb_pkg::*; #(
  parameter int RADIUS_MAX = RADIUS_MAX_DEF,
  parameter int WIDTH_MAX  = WIDTH_MAX_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    restart,
  input  logic                                    push,
  input  logic                                    cmd_full,
  input  logic [PIX_W-1:0]                        pixel,
  input  logic [$clog2(WIDTH_MAX)-1:0]            width_m1,
  input  logic [ROW_W-1:0]                        rows_m1,
  input  logic [$clog2(RADIUS_MAX+1)-1:0]         radius,
  output logic                                    cmd_push,
  output rbb_flags_t                              cmd_flags,
  output logic [PIX_W-1:0]                        cmd_pixel,
  output logic [$clog2(2*RADIUS_MAX+2)-1:0]       cmd_wr_addr,
  output logic [((($clog2(WIDTH_MAX)) > ($clog2(RADIUS_MAX+1) + 1)) ?
                 $clog2(WIDTH_MAX) : ($clog2(RADIUS_MAX+1) + 1)):0] cmd_pos
);

  localparam int RAD_W = $clog2(RADIUS_MAX + 1);
  localparam int AW    = $clog2(2 * RADIUS_MAX + 2);
  localparam int COL_W = $clog2(WIDTH_MAX);
  localparam int POS_W = ((COL_W > RAD_W + 1) ? COL_W : RAD_W + 1) + 1;
  localparam int CR_W  = (COL_W > RAD_W) ? COL_W : RAD_W;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [POS_W-1:0] col_ext;
  logic [CR_W-1:0]  col_cmp;
  logic [CR_W-1:0]  rad_cmp;
  logic             row_end;

  assign cmd_push = push && !cmd_full;
  assign col_ext  = POS_W'(col_r);
  assign col_cmp  = CR_W'(col_r);
  assign rad_cmp  = CR_W'(radius);
  assign row_end  = (col_r == width_m1);

  // Window position whose sample leaves the running sum for this pixel.
  assign cmd_pos     = col_ext - POS_W'({radius, 1'b1});
  assign cmd_wr_addr = col_ext[AW-1:0];
  assign cmd_pixel   = pixel;

  always_comb begin
    cmd_flags.first_col = (col_r == '0);
    cmd_flags.remove    = (col_cmp > rad_cmp);
    cmd_flags.emit      = (col_cmp >= rad_cmp);
    cmd_flags.row_end   = row_end;
    cmd_flags.frame_end = (row_r == rows_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd_push) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= (row_r >= rows_m1) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

endmodule

@@ design/rbb_back.sv @@
// ----------------------------------------------------------------------------
// rbb_back
// Keeps the row's recent pixels and running sum, walks a row's tail one result
// per cycle while there is result room, and divides each sum by the box width.
// ----------------------------------------------------------------------------
module rbb_back import rbb_pkg::*; #(
  parameter int RADIUS_MAX = RADIUS_MAX_DEF,
  parameter int WIDTH_MAX  = WIDTH_MAX_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [$clog2(RADIUS_MAX+1)-1:0]         radius,
  input  logic                                    cmd_empty,
  input  rbb_flags_t                              cmd_flags,
  input  logic [PIX_W-1:0]                        cmd_pixel,
  input  logic [$clog2(2*RADIUS_MAX+2)-1:0]       cmd_wr_addr,
  input  logic [((($clog2(WIDTH_MAX)) > ($clog2(RADIUS_MAX+1) + 1)) ?
                 $clog2(WIDTH_MAX) : ($clog2(RADIUS_MAX+1) + 1)):0] cmd_pos,
  output logic                                    cmd_pop,
  input  logic [OUT_CNT_W-1:0]                    res_count,
  output logic                                    res_push,
  output rbb_result_t                             res_word
);

  localparam int RAD_W  = $clog2(RADIUS_MAX + 1);
  localparam int AW     = $clog2(2 * RADIUS_MAX + 2);
  localparam int COL_W  = $clog2(WIDTH_MAX);
  localparam int POS_W  = ((COL_W > RAD_W + 1) ? COL_W : RAD_W + 1) + 1;
  localparam int SUM_W  = $clog2((2 * RADIUS_MAX + 1) * PIX_MAX + 1);
  localparam int N_W    = $clog2((2 * RADIUS_MAX + 1) * PIX_MAX + RADIUS_MAX + 1);
  localparam int DIV_K  = N_W + $clog2(2 * RADIUS_MAX + 1);
  localparam int M_W    = DIV_K + 1;
  localparam int PROD_W = N_W + M_W;
  localparam int USED_W = OUT_CNT_W + 2;

  rbb_state_t         state_r;
  rbb_state_t         state_nxt;
  rbb_flags_t         flags_r;
  logic [PIX_W-1:0]   pix_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_inc;
  logic [RAD_W-1:0]   steps_r;
  logic [PIX_W-1:0]   first_r;
  logic [SUM_W-1:0]   acc_r;
  logic [SUM_W-1:0]   acc_nxt;
  logic               emit_a_r;
  logic               lr_a_r;
  logic               lf_a_r;
  logic [PROD_W-1:0]  prod_r;
  logic               emit_b_r;
  logic               lr_b_r;
  logic               lf_b_r;
  logic [M_W-1:0]     recip_r;
  logic [M_W-1:0]     recip_tab [RADIUS_MAX+1];

  logic               ram_we;
  logic [AW-1:0]      rd_addr;
  logic [PIX_W-1:0]   ram_rdata;
  logic [PIX_W-1:0]   old_pix;
  logic [RAD_W:0]     rad_p1;
  logic [SUM_W:0]     init_sum;
  logic [SUM_W:0]     sum_in;
  logic [SUM_W:0]     sub_val;
  logic [USED_W-1:0]  used;
  logic               credit_ok;
  logic               take;
  logic               more;
  logic [N_W-1:0]     numer;

  // Reciprocals ceil(2^K / (2i+1)); with K this large the truncated product
  // gives the exact quotient for every sum the window can reach.
  for (genvar i = 0; i <= RADIUS_MAX; i++) begin : g_recip
    localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << DIV_K) + 64'(2 * i)) / 64'(2 * i + 1));
    assign recip_tab[i] = RECIP;
  end

  rbb_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (1 << AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_wr_addr),
    .wdata (cmd_pixel),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign pos_inc  = pos_r + POS_W'(1);
  // Positions left of the row repeat the first pixel.
  assign old_pix  = pos_r[POS_W-1] ? first_r : ram_rdata;
  assign rad_p1   = (RAD_W+1)'(radius) + (RAD_W+1)'(1);
  assign init_sum = (SUM_W+1)'(rad_p1) * (SUM_W+1)'(pix_r);
  assign sum_in   = flags_r.first_col ? init_sum
                                      : (SUM_W+1)'(acc_r) + (SUM_W+1)'(pix_r);
  assign sub_val  = flags_r.remove ? (SUM_W+1)'(old_pix) : '0;
  assign acc_nxt  = SUM_W'(sum_in - sub_val);

  assign used      = USED_W'(res_count) + USED_W'(emit_a_r) + USED_W'(emit_b_r);
  assign credit_ok = !flags_r.emit || (used < USED_W'(OUT_Q_DEPTH));

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    rd_addr   = pos_r[AW-1:0];
    take      = 1'b0;
    more      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          ram_we    = 1'b1;
          rd_addr   = cmd_pos[AW-1:0];
          state_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        if (credit_ok) begin
          take = 1'b1;
          more = flags_r.row_end && (steps_r != '0);
          if (more) begin
            rd_addr = pos_inc[AW-1:0];
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      emit_a_r <= 1'b0;
      emit_b_r <= 1'b0;
      acc_r    <= '0;
      first_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      emit_a_r <= take && flags_r.emit;
      emit_b_r <= emit_a_r;
      if (take) begin
        acc_r <= acc_nxt;
      end
      if (cmd_pop && cmd_flags.first_col) begin
        first_r <= cmd_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    recip_r <= recip_tab[radius];
    if (cmd_pop) begin
      flags_r <= cmd_flags;
      pix_r   <= cmd_pixel;
      pos_r   <= cmd_pos;
      steps_r <= radius;
    end else if (take && more) begin
      // Tail of the row: the right edge repeats the last pixel.
      pos_r             <= pos_inc;
      steps_r           <= steps_r - RAD_W'(1);
      flags_r.first_col <= 1'b0;
      flags_r.remove    <= 1'b1;
    end
    if (take) begin
      lr_a_r <= flags_r.row_end && !more;
      lf_a_r <= flags_r.row_end && !more && flags_r.frame_end;
    end
    if (emit_a_r) begin
      prod_r <= PROD_W'(numer) * PROD_W'(recip_r);
      lr_b_r <= lr_a_r;
      lf_b_r <= lf_a_r;
    end
  end

  // Adding r before the divide rounds to nearest; 2r+1 is odd, so no ties.
  assign numer = N_W'(acc_r) + N_W'(radius);

  assign res_push            = emit_b_r;
  assign res_word.pixel      = prod_r[DIV_K +: PIX_W];
  assign res_word.last_row   = lr_b_r;
  assign res_word.last_frame = lf_b_r;

endmodule

@@ design/running_box_blur_row_core.sv @@
// An accepted pixel passes the command queue, the back end's command, sum and product
// registers and the result queue. The back end reads the window RAM and updates the sum
// before it takes the next pixel; a row's last pixel releases r extra results in turn.
// Reset: synchronous, active low; registers return to radius 1, width 640, 480 rows,
// and both queues empty. The window RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// running_box_blur_row_core
// Horizontal box blur with edge replication over a raster stream of pixels.
// ----------------------------------------------------------------------------
module running_box_blur_row_core import rbb_pkg::*; #(
  parameter int RADIUS_MAX = RADIUS_MAX_DEF,
  parameter int WIDTH_MAX  = WIDTH_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input word queue
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [PIX_W-1:0]      in_pixel,
  // Result word queue
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [PIX_W-1:0]      out_blurred_pixel,
  output logic                  out_last_of_row,
  output logic                  out_last_of_frame,
  // Register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "running_box_blur_row_core_assert.svh"

  localparam int RAD_W = $clog2(RADIUS_MAX + 1);
  localparam int AW    = $clog2(2 * RADIUS_MAX + 2);
  localparam int COL_W = $clog2(WIDTH_MAX);
  localparam int WW    = $clog2(WIDTH_MAX + 1);
  localparam int POS_W = ((COL_W > RAD_W + 1) ? COL_W : RAD_W + 1) + 1;
  localparam int CMP_W = (WW > DIM_CFG_W) ? WW : DIM_CFG_W;
  localparam int RC_W  = (COL_W > RAD_W + RADIUS_CFG_W) ? COL_W : RAD_W + RADIUS_CFG_W;
  localparam int FLG_W = $bits(rbb_flags_t);
  localparam int CMD_W = FLG_W + PIX_W + AW + POS_W;
  localparam int RES_W = $bits(rbb_result_t);

  // The three registers. Writing any of them restarts the stream at the
  // first column of the first row; an index past the list is ignored.
  logic [RADIUS_CFG_W-1:0] box_radius_r;
  logic [DIM_CFG_W-1:0]    row_width_r;
  logic [DIM_CFG_W-1:0]    row_count_r;
  logic                    cfg_hit;

  always_comb begin
    case (rbb_cfg_idx_t'(cfg_index))
      CFG_BOX_RADIUS: cfg_hit = cfg_we;
      CFG_ROW_WIDTH:  cfg_hit = cfg_we;
      CFG_ROW_COUNT:  cfg_hit = cfg_we;
      default:        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_radius_r <= RST_BOX_RADIUS;
      row_width_r  <= RST_ROW_WIDTH;
      row_count_r  <= RST_ROW_COUNT;
    end else if (cfg_we) begin
      case (rbb_cfg_idx_t'(cfg_index))
        CFG_BOX_RADIUS: box_radius_r <= cfg_wdata[RADIUS_CFG_W-1:0];
        CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata;
        CFG_ROW_COUNT:  row_count_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Effective geometry. A width of zero counts as one and is saturated at
  // the largest supported row; the row count is held between one and the
  // frame limit. The radius is the least of the register, the build limit
  // and half of (width - 1), so a window never spans more than a row.
  logic [CMP_W-1:0]        width_ext;
  logic [CMP_W-1:0]        width_eff;
  logic [COL_W-1:0]        width_m1;
  logic [ROW_W-1:0]        rows_m1;
  logic [COL_W-1:0]        half_width;
  logic [RC_W-1:0]         rad_clip;
  logic [RAD_W-1:0]        radius;

  assign width_ext = CMP_W'(row_width_r);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_ext > CMP_W'(WIDTH_MAX)) begin
      width_eff = CMP_W'(WIDTH_MAX);
    end else begin
      width_eff = width_ext;
    end
  end

  assign width_m1   = COL_W'(width_eff - CMP_W'(1));
  assign half_width = width_m1 >> 1;

  always_comb begin
    if (row_count_r == '0) begin
      rows_m1 = '0;
    end else if (row_count_r > DIM_CFG_W'(ROWS_HIGH)) begin
      rows_m1 = ROW_W'(ROWS_HIGH - 1);
    end else begin
      rows_m1 = ROW_W'(row_count_r - DIM_CFG_W'(1));
    end
  end

  always_comb begin
    rad_clip = RC_W'(box_radius_r);
    if (rad_clip > RC_W'(RADIUS_MAX)) begin
      rad_clip = RC_W'(RADIUS_MAX);
    end
    if (rad_clip > RC_W'(half_width)) begin
      rad_clip = RC_W'(half_width);
    end
  end

  assign radius = RAD_W'(rad_clip);

  // Front end: counts columns and rows and turns each pixel into a command.
  logic             cmd_push;
  logic             cmd_pop;
  logic             cmd_full;
  logic             cmd_empty;
  rbb_flags_t       f_flags;
  logic [PIX_W-1:0] f_pixel;
  logic [AW-1:0]    f_wr_addr;
  logic [POS_W-1:0] f_pos;
  logic [CMD_W-1:0] cmd_wdata;
  logic [CMD_W-1:0] cmd_rdata;
  logic [$clog2(CMD_Q_DEPTH+1)-1:0] cmd_count;
  rbb_flags_t       b_flags;
  logic [PIX_W-1:0] b_pixel;
  logic [AW-1:0]    b_wr_addr;
  logic [POS_W-1:0] b_pos;

  assign in_full = cmd_full;

  rbb_front #(
    .RADIUS_MAX (RADIUS_MAX),
    .WIDTH_MAX  (WIDTH_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_hit),
    .push        (in_push),
    .cmd_full    (cmd_full),
    .pixel       (in_pixel),
    .width_m1    (width_m1),
    .rows_m1     (rows_m1),
    .radius      (radius),
    .cmd_push    (cmd_push),
    .cmd_flags   (f_flags),
    .cmd_pixel   (f_pixel),
    .cmd_wr_addr (f_wr_addr),
    .cmd_pos     (f_pos)
  );

  // Command queue: lets the front keep accepting while the back end is
  // busy with the tail of a row or waiting for result space.
  assign cmd_wdata = {f_flags, f_pixel, f_wr_addr, f_pos};

  rbb_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .full  (cmd_full),
    .count (cmd_count)
  );

  assign {b_flags, b_pixel, b_wr_addr, b_pos} = cmd_rdata;

  // Back end: running sum over the window RAM and the rounding divide. It
  // only starts a result when the result queue has room for it and for
  // everything still in its pipeline, so the queue never overflows.
  logic                  res_push;
  rbb_result_t           res_word;
  logic [RES_W-1:0]      res_rdata;
  rbb_result_t           res_head;
  logic                  res_full;
  logic [OUT_CNT_W-1:0]  res_count;

  rbb_back #(
    .RADIUS_MAX (RADIUS_MAX),
    .WIDTH_MAX  (WIDTH_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .radius      (radius),
    .cmd_empty   (cmd_empty),
    .cmd_flags   (b_flags),
    .cmd_pixel   (b_pixel),
    .cmd_wr_addr (b_wr_addr),
    .cmd_pos     (b_pos),
    .cmd_pop     (cmd_pop),
    .res_count   (res_count),
    .res_push    (res_push),
    .res_word    (res_word)
  );

  // Result queue: this is the output register stage seen by the consumer.
  rbb_fifo #(
    .DATA_W (RES_W),
    .DEPTH  (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .full  (res_full),
    .count (res_count)
  );

  assign res_head          = res_rdata;
  assign out_blurred_pixel = res_head.pixel;
  assign out_last_of_row   = res_head.last_row;
  assign out_last_of_frame = res_head.last_frame;

  // The back end's credit check must keep the result queue from overflowing.
  `RBB_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_push, !res_full, "result queue overflow")
  // The back end takes a command only when one is waiting.
  `RBB_ASSERT_IMP(a_cmd_no_underrun, clk, rst_n, cmd_pop, !cmd_empty, "command queue underrun")
  // An accepted pixel is waiting in the command queue on the next edge.
  `RBB_ASSERT_NXT(a_cmd_lands, clk, rst_n, in_push && !in_full, !cmd_empty, "accepted word lost")
  // The end of a frame is always also the end of a row.
  `RBB_ASSERT_IMP(a_frame_row, clk, rst_n, !out_empty && out_last_of_frame, out_last_of_row,
                  "frame end without row end")

endmodule
